// ----- sv/psde_pkg.sv -----
// Shared types, constants and CRC helper for the PNG stored-deflate encoder.
package psde_pkg;

    // Image limits and the stored-block size.
    localparam int unsigned MaxWidth       = 8192;
    localparam int unsigned MaxHeight      = 8192;
    localparam int unsigned StoredBlockMax = 65535;
    localparam int unsigned AdlerMod       = 65521;
    localparam int unsigned CmdDepth       = 4;

    localparam int DIM_W  = 14;
    localparam int COL_W  = 15;
    localparam int ROW_W  = 13;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // One classified word handed from the front to the back.
    typedef struct packed {
        logic             start;
        logic             filter;
        logic             last;
        logic [7:0]       data;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_entry;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/psde_cmd_fifo.sv -----
// Short queue of classified words between the front and the back.
module psde_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psde_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output psde_pkg::t_entry o_data,
    output logic            o_empty
);
    localparam int PW = $clog2(psde_pkg::CmdDepth);

    psde_pkg::t_entry r_mem [psde_pkg::CmdDepth];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == (PW+1)'(psde_pkg::CmdDepth));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
    end
endmodule

// ----- sv/psde_front.sv -----
// Front end: configuration registers, row/column tracking and word classification.
module psde_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [psde_pkg::DIM_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    input  logic [7:0]                 i_sample_byte,
    input  logic                       i_q_full,
    output logic                       o_q_push,
    output psde_pkg::t_entry           o_q_data
);
    logic [psde_pkg::DIM_W-1:0] r_cfg_w, r_cfg_h, r_w, r_h;
    logic [psde_pkg::DIM_W-1:0] w_weff, w_heff, w_wm1, w_hm1;
    logic [psde_pkg::COL_W-1:0] r_col;
    logic [psde_pkg::ROW_W-1:0] r_row;
    logic r_started, r_done;
    logic w_acc, w_row_end, w_last;

    function automatic logic [psde_pkg::DIM_W-1:0] clamp_dim(
        input logic [psde_pkg::DIM_W-1:0] v, input logic [psde_pkg::DIM_W-1:0] mx);
        if (v == '0)  return psde_pkg::DIM_W'(1);
        if (v > mx)   return mx;
        return v;
    endfunction

    // Dimensions in force: latched at stream start, else from the registers.
    assign w_weff = r_started ? r_w :
                    clamp_dim(r_cfg_w, psde_pkg::DIM_W'(psde_pkg::MaxWidth));
    assign w_heff = r_started ? r_h :
                    clamp_dim(r_cfg_h, psde_pkg::DIM_W'(psde_pkg::MaxHeight));
    assign w_wm1  = w_weff - psde_pkg::DIM_W'(1);
    assign w_hm1  = w_heff - psde_pkg::DIM_W'(1);

    assign w_acc     = i_push && !i_q_full;
    assign w_row_end = (r_col == {w_wm1[psde_pkg::ROW_W-1:0], 2'b11});
    assign w_last    = w_row_end && (r_row == w_hm1[psde_pkg::ROW_W-1:0]);

    // Classified word; samples after the end of the image are dropped here.
    assign o_q_push        = w_acc && !r_done;
    assign o_q_data.start  = !r_started;
    assign o_q_data.filter = (r_col == '0);
    assign o_q_data.last   = w_last;
    assign o_q_data.data   = i_sample_byte;
    assign o_q_data.width  = w_weff;
    assign o_q_data.height = w_heff;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= psde_pkg::DIM_W'(640);
            r_cfg_h <= psde_pkg::DIM_W'(480);
        end else if (i_cfg_we) begin
            if (i_cfg_addr == psde_pkg::CFG_WIDTH)  r_cfg_w <= i_cfg_wdata;
            if (i_cfg_addr == psde_pkg::CFG_HEIGHT) r_cfg_h <= i_cfg_wdata;
        end
    end

    // Stream position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_done    <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
        end else if (o_q_push) begin
            r_started <= 1'b1;
            if (w_last) r_done <= 1'b1;
            if (w_row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Latched dimensions.
    always_ff @(posedge i_clk) begin
        if (o_q_push && !r_started) begin
            r_w <= w_weff;
            r_h <= w_heff;
        end
    end
endmodule

// ----- sv/psde_back.sv -----
// Back end: byte sequencer, CRC-32, Adler-32, stored-block framing and output queue.
module psde_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psde_pkg::t_entry i_q_data,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [7:0]       o_out_byte,
    output logic             o_file_end
);
    localparam logic [1:0] PH_HDR   = 2'd0;
    localparam logic [1:0] PH_FILT  = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;
    localparam logic [5:0] HDR_LAST   = 6'd42;
    localparam logic [5:0] TRAIL_LAST = 6'd19;

    psde_pkg::t_entry r_cur;
    logic [1:0]  r_ph, n_ph;
    logic [5:0]  r_idx, n_idx;
    logic [2:0]  r_bh, n_bh;
    logic        r_busy, n_busy, r_done, n_done;
    logic [15:0] r_blk_left, n_blk_left;
    logic [29:0] r_raw_pos, n_raw_pos;
    logic [15:0] r_alo, n_alo, r_ahi, n_ahi;
    logic [31:0] r_crc;
    logic [psde_pkg::DIM_W-1:0] r_w, r_h;
    logic [29:0] r_raw_total;
    logic [14:0] r_blocks;
    logic [31:0] r_idat_len;

    logic [1:0]  r_oq_cnt;
    logic        r_oq_rd;
    logic [7:0]  r_oq_byte [2];
    logic        r_oq_end  [2];

    logic [7:0]  v_byte;
    logic        v_crc_en, v_crc_rst, v_end, v_bh;
    logic        w_emit, w_load, w_oq_pop, w_final;
    logic [29:0] w_rem;
    logic [15:0] w_len, w_nlen;
    logic [31:0] w_crc_out, w_adler;
    logic [16:0] w_lo_s, w_hi_s;
    logic [15:0] w_lo_n;
    logic [30:0] w_bx;
    logic [31:0] w_bt;

    // Length of the IDAT payload, worked out in a short pipeline after start.
    assign w_bx = {1'b0, r_raw_total} + 31'(psde_pkg::StoredBlockMax - 1);
    assign w_bt = {1'b0, w_bx} + {16'd0, w_bx[30:16]} + 32'd1;
    always_ff @(posedge i_clk) begin
        r_raw_total <= 30'(r_h) * 30'({r_w, 2'b01});
        r_blocks    <= w_bt[30:16];
        r_idat_len  <= {2'b00, r_raw_total} + 32'(r_blocks) * 32'd5 + 32'd6;
    end

    // Stored-block header fields.
    assign w_rem     = r_raw_total - r_raw_pos;
    assign w_final   = (w_rem <= 30'(psde_pkg::StoredBlockMax));
    assign w_len     = w_final ? w_rem[15:0] : 16'(psde_pkg::StoredBlockMax);
    assign w_nlen    = ~w_len;
    assign w_crc_out = r_crc ^ psde_pkg::CRC_INIT;
    assign w_adler   = {r_ahi, r_alo};

    // Adler-32 update, reduced on every byte.
    assign w_lo_s = {1'b0, r_alo} + {9'd0, v_byte};
    assign w_lo_n = (w_lo_s >= 17'(psde_pkg::AdlerMod)) ?
                    16'(w_lo_s - 17'(psde_pkg::AdlerMod)) : w_lo_s[15:0];
    assign w_hi_s = {1'b0, r_ahi} + {1'b0, w_lo_n};

    // Byte to emit in the current step.
    always_comb begin
        v_byte    = 8'd0;
        v_crc_en  = 1'b0;
        v_crc_rst = 1'b0;
        v_end     = 1'b0;
        v_bh      = 1'b0;
        unique case (r_ph)
            PH_HDR: begin
                case (r_idx)
                    6'd0:  v_byte = 8'd137;
                    6'd1:  v_byte = 8'd80;
                    6'd2:  v_byte = 8'd78;
                    6'd3:  v_byte = 8'd71;
                    6'd4:  v_byte = 8'd13;
                    6'd5:  v_byte = 8'd10;
                    6'd6:  v_byte = 8'd26;
                    6'd7:  v_byte = 8'd10;
                    6'd11: v_byte = 8'd13;
                    6'd12: begin v_byte = "I"; v_crc_en = 1'b1; v_crc_rst = 1'b1; end
                    6'd13: begin v_byte = "H"; v_crc_en = 1'b1; end
                    6'd14: begin v_byte = "D"; v_crc_en = 1'b1; end
                    6'd15: begin v_byte = "R"; v_crc_en = 1'b1; end
                    6'd16, 6'd17, 6'd20, 6'd21, 6'd26, 6'd27, 6'd28: v_crc_en = 1'b1;
                    6'd18: begin v_byte = {2'b00, r_cur.width[13:8]};  v_crc_en = 1'b1; end
                    6'd19: begin v_byte = r_cur.width[7:0];            v_crc_en = 1'b1; end
                    6'd22: begin v_byte = {2'b00, r_cur.height[13:8]}; v_crc_en = 1'b1; end
                    6'd23: begin v_byte = r_cur.height[7:0];           v_crc_en = 1'b1; end
                    6'd24: begin v_byte = 8'd8; v_crc_en = 1'b1; end
                    6'd25: begin v_byte = 8'd6; v_crc_en = 1'b1; end
                    6'd29: v_byte = w_crc_out[31:24];
                    6'd30: v_byte = w_crc_out[23:16];
                    6'd31: v_byte = w_crc_out[15:8];
                    6'd32: v_byte = w_crc_out[7:0];
                    6'd33: v_byte = r_idat_len[31:24];
                    6'd34: v_byte = r_idat_len[23:16];
                    6'd35: v_byte = r_idat_len[15:8];
                    6'd36: v_byte = r_idat_len[7:0];
                    6'd37: begin v_byte = "I"; v_crc_en = 1'b1; v_crc_rst = 1'b1; end
                    6'd38: begin v_byte = "D"; v_crc_en = 1'b1; end
                    6'd39: begin v_byte = "A"; v_crc_en = 1'b1; end
                    6'd40: begin v_byte = "T"; v_crc_en = 1'b1; end
                    6'd41: begin v_byte = 8'h78; v_crc_en = 1'b1; end
                    6'd42: begin v_byte = 8'h01; v_crc_en = 1'b1; end
                    default: v_byte = 8'd0;
                endcase
            end
            PH_FILT, PH_DATA: begin
                v_crc_en = 1'b1;
                if (r_blk_left == '0) begin
                    v_bh = 1'b1;
                    case (r_bh)
                        3'd0:    v_byte = {7'd0, w_final};
                        3'd1:    v_byte = w_len[7:0];
                        3'd2:    v_byte = w_len[15:8];
                        3'd3:    v_byte = w_nlen[7:0];
                        default: v_byte = w_nlen[15:8];
                    endcase
                end else begin
                    v_byte = (r_ph == PH_FILT) ? 8'd0 : r_cur.data;
                end
            end
            PH_TRAIL: begin
                case (r_idx)
                    6'd0:  begin v_byte = w_adler[31:24]; v_crc_en = 1'b1; end
                    6'd1:  begin v_byte = w_adler[23:16]; v_crc_en = 1'b1; end
                    6'd2:  begin v_byte = w_adler[15:8];  v_crc_en = 1'b1; end
                    6'd3:  begin v_byte = w_adler[7:0];   v_crc_en = 1'b1; end
                    6'd4,  6'd16: v_byte = w_crc_out[31:24];
                    6'd5,  6'd17: v_byte = w_crc_out[23:16];
                    6'd6,  6'd18: v_byte = w_crc_out[15:8];
                    6'd7:  v_byte = w_crc_out[7:0];
                    6'd19: begin v_byte = w_crc_out[7:0]; v_end = 1'b1; end
                    6'd12: begin v_byte = "I"; v_crc_en = 1'b1; v_crc_rst = 1'b1; end
                    6'd13: begin v_byte = "E"; v_crc_en = 1'b1; end
                    6'd14: begin v_byte = "N"; v_crc_en = 1'b1; end
                    6'd15: begin v_byte = "D"; v_crc_en = 1'b1; end
                    default: v_byte = 8'd0;
                endcase
            end
            default: v_byte = 8'd0;
        endcase
    end

    assign w_emit = r_busy && (r_oq_cnt != 2'd2);

    // Sequencer: step through the current word and fetch the next one.
    always_comb begin
        n_ph       = r_ph;
        n_idx      = r_idx;
        n_bh       = r_bh;
        n_busy     = r_busy;
        n_done     = r_done;
        n_blk_left = r_blk_left;
        n_raw_pos  = r_raw_pos;
        n_alo      = r_alo;
        n_ahi      = r_ahi;
        if (w_emit) begin
            unique case (r_ph)
                PH_HDR: begin
                    if (r_idx == HDR_LAST) begin
                        n_idx = '0;
                        n_ph  = r_cur.filter ? PH_FILT : PH_DATA;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_FILT, PH_DATA: begin
                    if (v_bh) begin
                        if (r_bh == 3'd4) begin
                            n_bh       = '0;
                            n_blk_left = w_len;
                        end else begin
                            n_bh = r_bh + 1'b1;
                        end
                    end else begin
                        n_blk_left = r_blk_left - 1'b1;
                        n_raw_pos  = r_raw_pos + 1'b1;
                        n_alo      = w_lo_n;
                        n_ahi      = (w_hi_s >= 17'(psde_pkg::AdlerMod)) ?
                                     16'(w_hi_s - 17'(psde_pkg::AdlerMod)) : w_hi_s[15:0];
                        if (r_ph == PH_FILT) begin
                            n_ph = PH_DATA;
                        end else if (r_cur.last) begin
                            n_ph  = PH_TRAIL;
                            n_idx = '0;
                        end else begin
                            n_busy = 1'b0;
                        end
                    end
                end
                PH_TRAIL: begin
                    if (r_idx == TRAIL_LAST) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                default: n_ph = r_ph;
            endcase
        end
        w_load = !n_busy && !n_done && !i_q_empty;
        if (w_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_ph   = i_q_data.start ? PH_HDR : (i_q_data.filter ? PH_FILT : PH_DATA);
        end
    end

    assign o_q_pop = w_load;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph       <= PH_HDR;
            r_idx      <= '0;
            r_bh       <= '0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_blk_left <= '0;
            r_raw_pos  <= '0;
            r_alo      <= 16'd1;
            r_ahi      <= '0;
            r_crc      <= psde_pkg::CRC_INIT;
        end else begin
            r_ph       <= n_ph;
            r_idx      <= n_idx;
            r_bh       <= n_bh;
            r_busy     <= n_busy;
            r_done     <= n_done;
            r_blk_left <= n_blk_left;
            r_raw_pos  <= n_raw_pos;
            r_alo      <= n_alo;
            r_ahi      <= n_ahi;
            if (w_emit && v_crc_en) begin
                r_crc <= psde_pkg::crc_byte(v_crc_rst ? psde_pkg::CRC_INIT : r_crc, v_byte);
            end
        end
    end

    // Current word and dimensions for this stream.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur <= i_q_data;
            if (i_q_data.start) begin
                r_w <= i_q_data.width;
                r_h <= i_q_data.height;
            end
        end
    end

    // Two-entry output queue.
    assign w_oq_pop   = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty    = (r_oq_cnt == 2'd0);
    assign o_out_byte = r_oq_byte[r_oq_rd];
    assign o_file_end = r_oq_end[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oq_byte[r_oq_rd ^ r_oq_cnt[0]] <= v_byte;
            r_oq_end[r_oq_rd ^ r_oq_cnt[0]]  <= v_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_cnt <= '0;
            r_oq_rd  <= 1'b0;
        end else begin
            r_oq_cnt <= r_oq_cnt + 2'(w_emit) - 2'(w_oq_pop);
            if (w_oq_pop) r_oq_rd <= ~r_oq_rd;
        end
    end

`ifndef ASSERT_OFF
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt != 2'd3)
        else $error("output queue count out of range");
    a_no_work_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && !o_q_pop)
        else $error("work fetched after the stream ended");
    a_hdr_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_ph == PH_HDR) |-> r_idx <= HDR_LAST)
        else $error("header index out of range");
    a_end_marks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && v_end) |=> r_done)
        else $error("last byte emitted without finishing");
`endif
endmodule

// ----- sv/png_stored_deflate_encoder_core.sv -----
// Top level of the streaming RGBA8 PNG encoder with stored deflate blocks.
// Sample bytes (R,G,B,A per pixel, rows top first) are pushed in; the PNG file
// comes out one byte per word on the result queue, with o_file_end set on the
// last IEND byte. Width and height registers are clamped to 1..8192 and latched
// by the first sample. The back end emits one byte per cycle while its output
// queue has room; the first sample adds 43 header bytes, during which the
// four-word queue fills and push stalls. Every 65535 raw bytes add a 5-byte
// block header, each row adds its filter byte, and the last sample adds 20
// trailer bytes. Samples after the end of the image are accepted and dropped.
module png_stored_deflate_encoder_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [psde_pkg::DIM_W-1:0] i_cfg_wdata,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [7:0]                 i_sample_byte,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [7:0]                 o_out_byte,
    output logic                       o_file_end
);
    psde_pkg::t_entry w_fq_in, w_fq_out;
    logic w_fq_push, w_fq_pop, w_fq_empty;

    psde_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (i_push),
        .i_sample_byte (i_sample_byte),
        .i_q_full      (o_full),
        .o_q_push      (w_fq_push),
        .o_q_data      (w_fq_in)
    );

    psde_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .i_data  (w_fq_in),
        .o_full  (o_full),
        .i_pop   (w_fq_pop),
        .o_data  (w_fq_out),
        .o_empty (w_fq_empty)
    );

    psde_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_data   (w_fq_out),
        .i_q_empty  (w_fq_empty),
        .o_q_pop    (w_fq_pop),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out_byte (o_out_byte),
        .o_file_end (o_file_end)
    );
endmodule

// ----- sim/tb_png_stored_deflate_encoder_core.sv -----
// Self-checking testbench for the streaming PNG stored-deflate encoder core.
`timescale 1ns / 1ps

module tb_png_stored_deflate_encoder_core;

    localparam int unsigned CycleLimit   = 100000;
    localparam int unsigned SettleCycles = 64;
    localparam int unsigned MaxReported  = 10;
    localparam int unsigned HoldCycles   = 400;
    localparam int unsigned ImageRows    = 120;

    // One byte of the PNG file as it should leave the block.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_png_byte;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_addr = psde_pkg::CFG_WIDTH;
    logic [psde_pkg::DIM_W-1:0]    i_cfg_wdata = '0;
    logic                          i_push = 1'b0;
    logic                          o_full;
    logic [7:0]                    i_sample_byte = 8'd0;
    logic                          o_empty;
    logic                          i_pop = 1'b0;
    logic [7:0]                    o_out_byte;
    logic                          o_file_end;

    // Expected file bytes, oldest first.
    t_png_byte   file_bytes_q[$];

    // Encoder shadow state.
    logic [psde_pkg::DIM_W-1:0] reg_width = 14'd640;
    logic [psde_pkg::DIM_W-1:0] reg_height = 14'd480;
    logic [31:0]  crc_run;
    int unsigned  adler_a;
    int unsigned  adler_b;
    int unsigned  raw_done;
    int unsigned  raw_count;
    int unsigned  row_pos;
    int unsigned  block_left;
    int unsigned  row_stride;
    bit           started;
    bit           finished;

    // Run controls and bookkeeping.
    int unsigned  send_idle_pct = 0;
    int unsigned  pop_stall_pct = 0;
    int unsigned  hold_requests = 0;
    bit           hold_active = 1'b0;
    int unsigned  samples_sent = 0;
    int unsigned  bytes_checked = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;
    int unsigned  total_samples;

    png_stored_deflate_encoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_sample_byte (i_sample_byte),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_out_byte    (o_out_byte),
        .o_file_end    (o_file_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reflected CRC-32 over one byte.
    function automatic logic [31:0] crc32_next(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (32'hEDB88320 ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    task automatic emit_byte(input logic [7:0] b, input bit with_crc, input bit last = 1'b0);
        t_png_byte e;
        e.data = b;
        e.last = last;
        file_bytes_q.insert(file_bytes_q.size(), e);
        if (with_crc) begin
            crc_run = crc32_next(crc_run, b);
        end
    endtask

    task automatic emit_word(input logic [31:0] v, input bit with_crc, input bit last = 1'b0);
        emit_byte(v[31:24], with_crc);
        emit_byte(v[23:16], with_crc);
        emit_byte(v[15:8], with_crc);
        emit_byte(v[7:0], with_crc, last);
    endtask

    task automatic emit_tag(input string t);
        for (int i = 0; i < 4; i++) begin
            emit_byte(t[i], 1'b1);
        end
    endtask

    // Signature, IHDR, IDAT length and type, zlib header.
    task automatic open_stream();
        int unsigned w;
        int unsigned h;
        int unsigned blocks;
        logic [7:0] sig[8];
        sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
        w = (reg_width < 1) ? 1 :
            (reg_width > psde_pkg::MaxWidth) ? psde_pkg::MaxWidth : reg_width;
        h = (reg_height < 1) ? 1 :
            (reg_height > psde_pkg::MaxHeight) ? psde_pkg::MaxHeight : reg_height;
        row_stride = 4 * w;
        raw_count = h * (1 + row_stride);
        blocks = (raw_count + psde_pkg::StoredBlockMax - 1) / psde_pkg::StoredBlockMax;
        foreach (sig[i]) emit_byte(sig[i], 1'b0);
        emit_word(32'd13, 1'b0);
        crc_run = 32'hFFFFFFFF;
        emit_tag("IHDR");
        emit_word(w, 1'b1);
        emit_word(h, 1'b1);
        emit_byte(8'd8, 1'b1);
        emit_byte(8'd6, 1'b1);
        emit_byte(8'd0, 1'b1);
        emit_byte(8'd0, 1'b1);
        emit_byte(8'd0, 1'b1);
        emit_word(crc_run ^ 32'hFFFFFFFF, 1'b0);
        emit_word(2 + raw_count + 5 * blocks + 4, 1'b0);
        crc_run = 32'hFFFFFFFF;
        emit_tag("IDAT");
        emit_byte(8'h78, 1'b1);
        emit_byte(8'h01, 1'b1);
        started = 1'b1;
    endtask

    // One raw byte of the zlib payload, with a stored-block header when due.
    task automatic add_raw(input logic [7:0] b);
        int unsigned rem;
        logic [15:0] len;
        if (raw_done >= raw_count) return;
        if (block_left == 0) begin
            rem = raw_count - raw_done;
            len = (rem > psde_pkg::StoredBlockMax) ? 16'(psde_pkg::StoredBlockMax)
                                                   : rem[15:0];
            emit_byte((rem <= psde_pkg::StoredBlockMax) ? 8'd1 : 8'd0, 1'b1);
            emit_byte(len[7:0], 1'b1);
            emit_byte(len[15:8], 1'b1);
            emit_byte(~len[7:0], 1'b1);
            emit_byte(~len[15:8], 1'b1);
            block_left = len;
        end
        emit_byte(b, 1'b1);
        adler_a = (adler_a + b) % psde_pkg::AdlerMod;
        adler_b = (adler_b + adler_a) % psde_pkg::AdlerMod;
        block_left--;
        raw_done++;
    endtask

    // Adler-32, IDAT CRC and the IEND chunk.
    task automatic close_stream();
        emit_word({adler_b[15:0], adler_a[15:0]}, 1'b1);
        emit_word(crc_run ^ 32'hFFFFFFFF, 1'b0);
        emit_word(32'd0, 1'b0);
        crc_run = 32'hFFFFFFFF;
        emit_tag("IEND");
        emit_word(crc_run ^ 32'hFFFFFFFF, 1'b0, 1'b1);
        finished = 1'b1;
    endtask

    // Expected file bytes caused by one accepted sample.
    task automatic predict_sample(input logic [7:0] b);
        if (!started) open_stream();
        if (!finished) begin
            if (row_pos == 0) add_raw(8'd0);
            add_raw(b);
            row_pos++;
            if (row_pos >= row_stride) row_pos = 0;
            if (raw_done >= raw_count) close_stream();
        end
    endtask

    // Offer one sample word and wait until it is taken; push stays high afterwards.
    task automatic send_sample(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_sample_byte <= b;
        do @(posedge i_clk); while (o_full);
        predict_sample(b);
        samples_sent++;
    endtask

    task automatic stop_push();
        i_push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (file_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Register write; only issued while nothing is in flight.
    task automatic write_reg(input logic idx, input logic [psde_pkg::DIM_W-1:0] val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == psde_pkg::CFG_WIDTH) reg_width = val;
        else reg_height = val;
        @(posedge i_clk);
    endtask

    // Random sample byte, biased towards the extremes now and then.
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(7))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Register extremes before the stream starts; width 0 clamps to 1, 1 x 120 is latched.
    task automatic test_register_extremes();
        write_reg(psde_pkg::CFG_WIDTH, 14'd0);
        write_reg(psde_pkg::CFG_HEIGHT, 14'd0);
        write_reg(psde_pkg::CFG_HEIGHT, 14'd16383);
        write_reg(psde_pkg::CFG_WIDTH, 14'd16383);
        write_reg(psde_pkg::CFG_WIDTH, 14'd0);
        write_reg(psde_pkg::CFG_HEIGHT, 14'(ImageRows));
    endtask

    // Header start and the extremes of the sample byte, without idling.
    task automatic test_directed_samples();
        logic [7:0] pattern[$];
        pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h04, 8'h08,
                    8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'h7F, 8'hFF, 8'hFF};
        send_idle_pct = 0;
        pop_stall_pct = 0;
        foreach (pattern[i]) send_sample(pattern[i]);
        stop_push();
    endtask

    // Long receiver hold-off while the sender keeps pushing, then a full drain.
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_requests++;
        repeat (200) send_sample(pick_sample());
        stop_push();
        wait_drained();
    endtask

    // Registers written in mid-stream must not disturb the latched dimensions.
    task automatic test_midstream_config();
        write_reg(psde_pkg::CFG_WIDTH, 14'd1);
        write_reg(psde_pkg::CFG_HEIGHT, 14'd8192);
    endtask

    // Remaining samples across four phases of sender idling and receiver stalls.
    task automatic test_random_phases();
        int unsigned per_phase;
        int unsigned target;
        int unsigned stall[4];
        int unsigned idle[4];
        idle  = '{0, 61, 0, 10};
        stall = '{0, 0, 61, 10};
        per_phase = (total_samples - samples_sent) / 4;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle[p];
            pop_stall_pct = stall[p];
            target = (p == 3) ? total_samples : samples_sent + per_phase;
            while (samples_sent < target) begin
                send_sample(pick_sample());
            end
            stop_push();
        end
    endtask

    // Samples past the end of the image are dropped and produce nothing; then the registers are rewritten.
    task automatic test_after_end();
        send_idle_pct = 10;
        pop_stall_pct = 10;
        repeat (20) send_sample(pick_sample());
        stop_push();
        write_reg(psde_pkg::CFG_WIDTH, 14'd8192);
        write_reg(psde_pkg::CFG_HEIGHT, 14'd1);
    endtask

    // Receiver hold-off, counted in cycles here.
    initial begin : hold_ctrl
        int unsigned served;
        served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != served) begin
                served++;
                hold_active <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                hold_active <= 1'b0;
            end
        end
    end

    // Result side: check each taken word, then choose the next pop.
    always @(posedge i_clk) begin
        t_png_byte e;
        if (i_rst_n && i_pop && !o_empty) begin
            if (file_bytes_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReported)
                    $display("ERROR: unexpected word byte=%02h end=%0b", o_out_byte, o_file_end);
            end else begin
                e = file_bytes_q.pop_front();
                if (o_out_byte !== e.data || o_file_end !== e.last) begin
                    mismatches++;
                    if (mismatches <= MaxReported)
                        $display("ERROR: word %0d expected byte=%02h end=%0b got byte=%02h end=%0b",
                                 bytes_checked, e.data, e.last, o_out_byte, o_file_end);
                end
                bytes_checked++;
            end
        end
        if (hold_active) begin
            i_pop <= 1'b0;
        end else begin
            i_pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    // Watchdog.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Test sequence.
    initial begin
        crc_run    = 32'hFFFFFFFF;
        adler_a    = 1;
        adler_b    = 0;
        raw_done   = 0;
        raw_count  = 0;
        row_pos    = 0;
        block_left = 0;
        row_stride = 0;
        started    = 1'b0;
        finished   = 1'b0;
        // One pixel per row, four sample bytes each.
        total_samples = 4 * ImageRows;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_extremes();
        test_directed_samples();
        test_backpressure();
        test_midstream_config();
        test_random_phases();
        test_after_end();

        wait_drained();
        $display("Streamed a 1x%0d image from %0d samples, %0d file bytes checked,",
                 ImageRows, samples_sent, bytes_checked);
        $display("covering clamped registers, idle and stall phases, a long hold-off and extras.");
        if (mismatches == 0 && file_bytes_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
